// File: hw/rtl/ttcd_pkg.sv
// ----------------------------------------------------------------------------
// ttcd_pkg
// Shared constants and a small table for the timestamp to civil date and time
// converter.
// ----------------------------------------------------------------------------
package ttcd_pkg;

    localparam int FRACTION_BITS_DEF = 30;
    localparam int TS_W              = 63;

    // Quotient bits resolved in each register stage of a constant divider.
    localparam int DIV_STEP          = 4;

    localparam int US_PER_SEC        = 1000000;
    localparam int SEC_DIV_ODD       = 675;      // 86400 = 675 * 128
    localparam int SEC_DIV_SHIFT     = 7;
    localparam int DAYS_TO_EPOCH     = 719468 + 17532;
    localparam int ERA_DAYS          = 146097;
    localparam int CENT_DAYS         = 36524;
    localparam int QUAD_DAYS         = 1460;
    localparam int YEAR_DAYS         = 365;
    localparam int MONTH_SPAN        = 153;
    localparam int SEC_PER_HOUR      = 3600;
    localparam int SEC_PER_MIN       = 60;

    // First day of year (March based) of each shifted month: (153 * mp + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        begin
            case (mp)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd92;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd184;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd245;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/timestamp_to_civil_datetime.sv
// ----------------------------------------------------------------------------
// timestamp_to_civil_datetime
// Converts a fixed-point timestamp since 2018-01-01 into a Gregorian date and
// a time of day rounded to the microsecond.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy is always
// low, so one timestamp can be issued per clock. Each request produces exactly
// one result, presented for a single cycle with done high, in request order.
// The pipeline is a chain of constant dividers (seconds per day, days per era,
// the four-year, year and month splits and the hour and minute splits), each
// of which resolves four quotient bits per stage. Fewer fraction bits widen
// the day count and add stages to the day and era dividers. The receiver
// cannot stall the pipeline, so results must be taken when offered.
module timestamp_to_civil_datetime #(
    parameter int FRACTION_BITS = ttcd_pkg::FRACTION_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [ttcd_pkg::TS_W-1:0] timestamp,
    output logic                      done,
    output logic [11:0]               year,
    output logic [3:0]                month,
    output logic [4:0]                day,
    output logic [4:0]                hour,
    output logic [5:0]                minute,
    output logic [5:0]                second,
    output logic [19:0]               microsecond
);
    import ttcd_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int FW      = (F > 0) ? F : 1;
    localparam int PROD_W  = FW + 20;
    localparam int WHOLE_W = TS_W - F;
    localparam int SECS_W  = WHOLE_W + 1;
    localparam int DAYS_W  = SECS_W - SEC_DIV_SHIFT;
    localparam logic [PROD_W:0] HALF =
        (F > 0) ? ((PROD_W + 1)'(1) << (FW - 1)) : '0;

    typedef struct packed {
        logic [19:0] us;
        logic [6:0]  low7;
    } p1_t;

    typedef struct packed {
        logic [16:0] sod;
        logic [19:0] us;
    } p2_t;

    typedef struct packed {
        logic [11:0] era;
        logic [17:0] doe;
        logic [2:0]  cent;
        logic        last;
        logic [16:0] sod;
        logic [19:0] us;
    } p3_t;

    typedef struct packed {
        logic [11:0] era;
        logic [17:0] doe;
        logic [16:0] sod;
        logic [19:0] us;
    } p4_t;

    typedef struct packed {
        logic [11:0] y;
        logic [8:0]  doy;
        logic [16:0] sod;
        logic [19:0] us;
    } p5_t;

    typedef struct packed {
        logic [11:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [19:0] us;
    } p6_t;

    typedef struct packed {
        logic [11:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        logic [4:0]  hh;
        logic [19:0] us;
    } p7_t;

    assign busy = 1'b0;

    // Stage 1: fraction times one million.
    logic [TS_W-1:0]    shifted;
    logic [FW-1:0]      frac;
    logic               v1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [WHOLE_W-1:0] whole_reg;

    assign shifted = timestamp >> F;
    assign frac    = (F > 0) ? timestamp[FW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(frac) * PROD_W'(US_PER_SEC);
        whole_reg <= shifted[WHOLE_W-1:0];
    end

    // Stage 2: round to the microsecond and carry a full second.
    logic [PROD_W:0]   rsum;
    logic [PROD_W:0]   rsh;
    logic [19:0]       us_raw;
    logic              us_carry;
    logic              v2_reg;
    logic [SECS_W-1:0] secs_reg;
    logic [19:0]       us2_reg;

    assign rsum     = {1'b0, prod_reg} + HALF;
    assign rsh      = rsum >> F;
    assign us_raw   = rsh[19:0];
    assign us_carry = (us_raw >= 20'(US_PER_SEC));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_reg <= {1'b0, whole_reg} + SECS_W'(us_carry);
        us2_reg  <= us_carry ? (us_raw - 20'(US_PER_SEC)) : us_raw;
    end

    // Seconds per day, split into a shift and a division by 675.
    logic              d1_v;
    logic [DAYS_W-1:0] d1_q;
    logic [9:0]        d1_r;
    p1_t               d1_pi;
    p1_t               d1_po;

    assign d1_pi.us   = us2_reg;
    assign d1_pi.low7 = secs_reg[SEC_DIV_SHIFT-1:0];

    ttcd_cdiv #(
        .NUM_W (DAYS_W),
        .DEN_W (10),
        .DEN   (SEC_DIV_ODD),
        .STEP  (DIV_STEP),
        .PW    ($bits(p1_t))
    ) u_div_day (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .num       (secs_reg[SECS_W-1:SEC_DIV_SHIFT]),
        .pay_in    (d1_pi),
        .out_valid (d1_v),
        .quo       (d1_q),
        .rem       (d1_r),
        .pay_out   (d1_po)
    );

    // Move the day count to the 0000-03-01 origin.
    logic              v3_reg;
    logic [DAYS_W-1:0] days_reg;
    p2_t               p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= d1_v;
        end
    end

    always_ff @(posedge clk)
    begin
        days_reg   <= d1_q + DAYS_W'(DAYS_TO_EPOCH);
        p3_reg.sod <= {d1_r, d1_po.low7};
        p3_reg.us  <= d1_po.us;
    end

    // Days per 400-year era.
    logic              d2_v;
    logic [DAYS_W-1:0] d2_q;
    logic [17:0]       d2_r;
    p2_t               d2_po;

    ttcd_cdiv #(
        .NUM_W (DAYS_W),
        .DEN_W (18),
        .DEN   (ERA_DAYS),
        .STEP  (DIV_STEP),
        .PW    ($bits(p2_t))
    ) u_div_era (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .num       (days_reg),
        .pay_in    (p3_reg),
        .out_valid (d2_v),
        .quo       (d2_q),
        .rem       (d2_r),
        .pay_out   (d2_po)
    );

    // Centuries within the era take a few compares; the four-year split divides.
    p3_t         d3_pi;
    logic        d3_v;
    logic [17:0] d3_q;
    logic [10:0] d3_r;
    p3_t         d3_po;

    always_comb
    begin
        d3_pi.era  = d2_q[11:0];
        d3_pi.doe  = d2_r;
        d3_pi.cent = 3'(d2_r >= 18'(CENT_DAYS)) + 3'(d2_r >= 18'(2 * CENT_DAYS))
                   + 3'(d2_r >= 18'(3 * CENT_DAYS)) + 3'(d2_r >= 18'(4 * CENT_DAYS));
        d3_pi.last = (d2_r == 18'(ERA_DAYS - 1));
        d3_pi.sod  = d2_po.sod;
        d3_pi.us   = d2_po.us;
    end

    ttcd_cdiv #(
        .NUM_W (18),
        .DEN_W (11),
        .DEN   (QUAD_DAYS),
        .STEP  (DIV_STEP),
        .PW    ($bits(p3_t))
    ) u_div_quad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_v),
        .num       (d2_r),
        .pay_in    (d3_pi),
        .out_valid (d3_v),
        .quo       (d3_q),
        .rem       (d3_r),
        .pay_out   (d3_po)
    );

    logic        v4_reg;
    logic [17:0] x_reg;
    p4_t         p4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= d3_v;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= d3_po.doe - d3_q + 18'(d3_po.cent) - 18'(d3_po.last);
        p4_reg.era <= d3_po.era;
        p4_reg.doe <= d3_po.doe;
        p4_reg.sod <= d3_po.sod;
        p4_reg.us  <= d3_po.us;
    end

    // Year of era.
    logic        d4_v;
    logic [17:0] d4_q;
    logic [8:0]  d4_r;
    p4_t         d4_po;

    ttcd_cdiv #(
        .NUM_W (18),
        .DEN_W (9),
        .DEN   (YEAR_DAYS),
        .STEP  (DIV_STEP),
        .PW    ($bits(p4_t))
    ) u_div_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .num       (x_reg),
        .pay_in    (p4_reg),
        .out_valid (d4_v),
        .quo       (d4_q),
        .rem       (d4_r),
        .pay_out   (d4_po)
    );

    logic [8:0]  yoe;
    logic [1:0]  yoe_cent;
    logic [17:0] year_days;
    logic [20:0] era_years;
    logic        v5_reg;
    logic [10:0] mnum_reg;
    p5_t         p5_reg;
    logic [8:0]  p5_next_doy;

    // The remainder of the year split is not the day of year: doe, not x, is used.
    assign yoe       = d4_q[8:0] | 9'(d4_r & 9'd0);
    assign yoe_cent  = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);
    assign year_days = 18'(yoe) * 18'(YEAR_DAYS) + 18'(yoe[8:2]) - 18'(yoe_cent);
    assign era_years = 21'(d4_po.era) * 21'd400;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= d4_v;
        end
    end

    always_comb
    begin
        logic [17:0] doy_w;
        doy_w = d4_po.doe - year_days;
        p5_next_doy = doy_w[8:0];
    end

    always_ff @(posedge clk)
    begin
        p5_reg.y   <= era_years[11:0] + 12'(yoe);
        p5_reg.doy <= p5_next_doy;
        p5_reg.sod <= d4_po.sod;
        p5_reg.us  <= d4_po.us;
        mnum_reg   <= 11'(p5_next_doy) * 11'd5 + 11'd2;
    end

    // Shifted month.
    logic        d5_v;
    logic [10:0] d5_q;
    logic [7:0]  d5_r;
    p5_t         d5_po;

    ttcd_cdiv #(
        .NUM_W (11),
        .DEN_W (8),
        .DEN   (MONTH_SPAN),
        .STEP  (DIV_STEP),
        .PW    ($bits(p5_t))
    ) u_div_month (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v5_reg),
        .num       (mnum_reg),
        .pay_in    (p5_reg),
        .out_valid (d5_v),
        .quo       (d5_q),
        .rem       (d5_r),
        .pay_out   (d5_po)
    );

    logic [3:0] mp;
    logic [3:0] mon;
    logic [8:0] dom;
    logic       v6_reg;
    logic [16:0] sod6_reg;
    p6_t        p6_reg;

    assign mp  = d5_q[3:0] | 4'(d5_r & 8'd0);
    assign mon = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
    assign dom = d5_po.doy - month_start(mp) + 9'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= d5_v;
        end
    end

    always_ff @(posedge clk)
    begin
        p6_reg.y  <= d5_po.y + 12'(mon <= 4'd2);
        p6_reg.m  <= mon;
        p6_reg.d  <= dom[4:0];
        p6_reg.us <= d5_po.us;
        sod6_reg  <= d5_po.sod;
    end

    // Hours, then minutes and seconds.
    logic        d6_v;
    logic [16:0] d6_q;
    logic [11:0] d6_r;
    p6_t         d6_po;
    p7_t         d7_pi;

    ttcd_cdiv #(
        .NUM_W (17),
        .DEN_W (12),
        .DEN   (SEC_PER_HOUR),
        .STEP  (DIV_STEP),
        .PW    ($bits(p6_t))
    ) u_div_hour (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v6_reg),
        .num       (sod6_reg),
        .pay_in    (p6_reg),
        .out_valid (d6_v),
        .quo       (d6_q),
        .rem       (d6_r),
        .pay_out   (d6_po)
    );

    assign d7_pi.y  = d6_po.y;
    assign d7_pi.m  = d6_po.m;
    assign d7_pi.d  = d6_po.d;
    assign d7_pi.hh = d6_q[4:0];
    assign d7_pi.us = d6_po.us;

    logic        d7_v;
    logic [11:0] d7_q;
    logic [5:0]  d7_r;
    p7_t         d7_po;

    ttcd_cdiv #(
        .NUM_W (12),
        .DEN_W (6),
        .DEN   (SEC_PER_MIN),
        .STEP  (DIV_STEP),
        .PW    ($bits(p7_t))
    ) u_div_min (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d6_v),
        .num       (d6_r),
        .pay_in    (d7_pi),
        .out_valid (d7_v),
        .quo       (d7_q),
        .rem       (d7_r),
        .pay_out   (d7_po)
    );

    // Output register.
    logic        done_reg;
    p7_t         out_reg;
    logic [5:0]  mm_reg;
    logic [5:0]  ss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= d7_v;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= d7_po;
        mm_reg  <= d7_q[5:0];
        ss_reg  <= d7_r;
    end

    assign done        = done_reg;
    assign year        = out_reg.y;
    assign month       = out_reg.m;
    assign day         = out_reg.d;
    assign hour        = out_reg.hh;
    assign minute      = mm_reg;
    assign second      = ss_reg;
    assign microsecond = out_reg.us;

endmodule

// File: hw/rtl/ttcd_cdiv.sv
// ----------------------------------------------------------------------------
// ttcd_cdiv
// Pipelined restoring divider by a constant, STEP quotient bits per stage,
// with a side payload that travels alongside.
// ----------------------------------------------------------------------------
module ttcd_cdiv #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 11,
    parameter int DEN   = 1460,
    parameter int STEP  = 4,
    parameter int PW    = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [PW-1:0]    pay_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [PW-1:0]    pay_out
);
    import ttcd_pkg::*;

    localparam int STAGES = (NUM_W + STEP - 1) / STEP;
    localparam logic [DEN_W:0] DEN_X = (DEN_W + 1)'(DEN);

    // Consumed numerator bits are replaced by quotient bits as they resolve.
    logic [NUM_W-1:0] w_reg [STAGES];
    logic [DEN_W-1:0] r_reg [STAGES];
    logic [PW-1:0]    p_reg [STAGES];
    logic             v_reg [STAGES];

    logic [NUM_W-1:0] w_in [STAGES];
    logic [DEN_W-1:0] r_in [STAGES];
    logic [PW-1:0]    p_in [STAGES];
    logic             v_in [STAGES];

    genvar s;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            localparam int BASE = NUM_W - 1 - s * STEP;
            logic [NUM_W-1:0] w_next;
            logic [DEN_W-1:0] r_next;

            if (s == 0)
            begin : g_first
                assign w_in[s] = num;
                assign r_in[s] = '0;
                assign p_in[s] = pay_in;
                assign v_in[s] = in_valid;
            end
            else
            begin : g_rest
                assign w_in[s] = w_reg[s-1];
                assign r_in[s] = r_reg[s-1];
                assign p_in[s] = p_reg[s-1];
                assign v_in[s] = v_reg[s-1];
            end

            always_comb
            begin
                logic [DEN_W:0] t;
                w_next = w_in[s];
                r_next = r_in[s];
                t      = '0;
                for (int k = 0; k < STEP; k++)
                begin
                    if (BASE - k >= 0)
                    begin
                        t = {r_next, w_next[BASE-k]};
                        if (t >= DEN_X)
                        begin
                            t = t - DEN_X;
                            w_next[BASE-k] = 1'b1;
                        end
                        else
                        begin
                            w_next[BASE-k] = 1'b0;
                        end
                        r_next = t[DEN_W-1:0];
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else
                begin
                    v_reg[s] <= v_in[s];
                end
            end

            always_ff @(posedge clk)
            begin
                w_reg[s] <= w_next;
                r_reg[s] <= r_next;
                p_reg[s] <= p_in[s];
            end
        end
    endgenerate

    assign out_valid = v_reg[STAGES-1];
    assign quo       = w_reg[STAGES-1];
    assign rem       = r_reg[STAGES-1];
    assign pay_out   = p_reg[STAGES-1];

endmodule

// File: tb/timestamp_to_civil_datetime_tb.sv
// ----------------------------------------------------------------------------
// timestamp_to_civil_datetime_tb
// Drives fixed-point timestamps into the converter and checks every date and
// time of day against a predictor built on the era-based calendar split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timestamp_to_civil_datetime_tb;

    import ttcd_pkg::*;

    localparam int FB          = ttcd_pkg::FRACTION_BITS_DEF;
    localparam int WDOG_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 200;
    localparam longint unsigned DAY_SECS = 86400;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [19:0] microsecond;
    } civil_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [ttcd_pkg::TS_W-1:0] timestamp;
    logic                      done;
    logic [11:0]               year;
    logic [3:0]                month;
    logic [4:0]                day;
    logic [4:0]                hour;
    logic [5:0]                minute;
    logic [5:0]                second;
    logic [19:0]               microsecond;

    civil_t pending_dates[$];
    int     mismatch_count;
    int     request_count;
    int     result_count;
    int     idle_cycles;
    bit     no_idle;

    timestamp_to_civil_datetime dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .timestamp   (timestamp),
        .done        (done),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .microsecond (microsecond)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic civil_t civil_from_stamp(input logic [62:0] ts);
        longint unsigned frac, us, secs, days, sod, era, doe, yoe, y, doy, mp, d, m;
        longint unsigned hh, rem_s, mm, ss;
        civil_t c;
        begin
            secs = longint'(ts) >> FB;
            frac = longint'(ts) & ((64'd1 << FB) - 1);
            us   = frac * 1000000;
            if (FB > 0)
                us = (us + (64'd1 << (FB - 1))) >> FB;
            if (us >= 1000000)
            begin
                us   = us - 1000000;
                secs = secs + 1;
            end
            days = secs / DAY_SECS + 719468 + 17532;
            sod  = secs % DAY_SECS;
            era  = days / 146097;
            doe  = days - era * 146097;
            yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            y    = yoe + era * 400;
            doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp   = (5 * doy + 2) / 153;
            d    = doy - (153 * mp + 2) / 5 + 1;
            m    = (mp < 10) ? mp + 3 : mp - 9;
            if (m <= 2)
                y = y + 1;
            hh    = sod / 3600;
            rem_s = sod - hh * 3600;
            mm    = rem_s / 60;
            ss    = rem_s - mm * 60;
            c.year        = y[11:0];
            c.month       = m[3:0];
            c.day         = d[4:0];
            c.hour        = hh[4:0];
            c.minute      = mm[5:0];
            c.second      = ss[5:0];
            c.microsecond = us[19:0];
            return c;
        end
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        begin
            mismatch_count++;
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     result_count, field, got, want);
        end
    endtask

    // Requests and results are both seen at the clock edge that accepts them.
    always @(posedge clk)
    begin
        civil_t want;
        bit     accepted;
        accepted = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_dates.push_back(civil_from_stamp(timestamp));
                request_count++;
                accepted = 1'b1;
            end
            if (done)
            begin
                accepted = 1'b1;
                if (pending_dates.size() == 0)
                begin
                    mismatch_count++;
                    $display("result %0d arrived with nothing outstanding", result_count);
                end
                else
                begin
                    want = pending_dates.pop_front();
                    if (year != want.year)   report_mismatch("year", year, want.year);
                    if (month != want.month) report_mismatch("month", month, want.month);
                    if (day != want.day)     report_mismatch("day", day, want.day);
                    if (hour != want.hour)   report_mismatch("hour", hour, want.hour);
                    if (minute != want.minute)
                        report_mismatch("minute", minute, want.minute);
                    if (second != want.second)
                        report_mismatch("second", second, want.second);
                    if (microsecond != want.microsecond)
                        report_mismatch("microsecond", microsecond, want.microsecond);
                end
                result_count++;
            end
            idle_cycles <= accepted ? 0 : idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT)
            begin
                $display("FAIL timestamp_to_civil_datetime");
                $finish;
            end
        end
    end

    task automatic send_stamp(input logic [62:0] ts);
        int  gap;
        bit  taken;
        begin
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start     <= 1'b1;
            timestamp <= ts;
            taken = 1'b0;
            while (!taken)
            begin
                @(negedge clk);
                taken = !busy;
                @(posedge clk);
            end
        end
    endtask

    function automatic logic [62:0] stamp_of(input longint unsigned secs,
                                             input longint unsigned frac);
        return 63'((secs << FB) | frac);
    endfunction

    task automatic test_directed();
        longint unsigned leap_day, century_feb;
        begin
            leap_day    = (365 + 365 + 59) * DAY_SECS;
            // 2100 is not a leap year: 28 February 2100 to 1 March 2100.
            century_feb = (82 * 365 + 20 + 58) * DAY_SECS;
            send_stamp(63'd0);
            send_stamp({63{1'b1}});
            send_stamp(stamp_of(0, (64'd1 << FB) - 1));
            send_stamp(stamp_of(0, 64'd1 << (FB - 1)));
            send_stamp(stamp_of(0, 1));
            send_stamp(stamp_of(59, (64'd1 << FB) - 1));
            send_stamp(stamp_of(3599, (64'd1 << FB) - 1));
            send_stamp(stamp_of(DAY_SECS - 1, (64'd1 << FB) - 1));
            send_stamp(stamp_of(DAY_SECS - 1, 0));
            send_stamp(stamp_of(365 * DAY_SECS - 1, (64'd1 << FB) - 1));
            send_stamp(stamp_of(leap_day, 0));
            send_stamp(stamp_of(leap_day - 1, (64'd1 << FB) - 1));
            send_stamp(stamp_of(leap_day + DAY_SECS, 12345));
            send_stamp(stamp_of(century_feb, 0));
            send_stamp(stamp_of(century_feb + DAY_SECS, 0));
            send_stamp(stamp_of(century_feb + DAY_SECS - 1, (64'd1 << FB) - 1));
            send_stamp(63'h2AAA_AAAA_AAAA_AAAA);
            send_stamp(63'h5555_5555_5555_5555);
            send_stamp(stamp_of((64'd1 << (63 - FB)) - 1, 0));
        end
    endtask

    task automatic test_random(input int count);
        longint unsigned secs, frac;
        logic [62:0]     ts;
        begin
            for (int i = 0; i < count; i++)
            begin
                ts   = 63'({$urandom, $urandom});
                secs = longint'(ts) >> FB;
                frac = longint'(ts) & ((64'd1 << FB) - 1);
                case ($urandom_range(0, 4))
                    0: ;
                    1: secs = secs - (secs % DAY_SECS) + DAY_SECS - 1;
                    2: frac = (64'd1 << FB) - $urandom_range(1, 600);
                    3: secs = secs % (5 * 365 * DAY_SECS);
                    default: frac = (64'd1 << (FB - 1)) + $urandom_range(0, 3) - 2;
                endcase
                ts = stamp_of(secs & ((64'd1 << (63 - FB)) - 1), frac);
                send_stamp(ts);
            end
        end
    endtask

    task automatic test_back_to_back(input int count);
        begin
            no_idle = 1'b1;
            test_random(count);
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        timestamp      = '0;
        mismatch_count = 0;
        request_count  = 0;
        result_count   = 0;
        idle_cycles    = 0;
        no_idle        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(700);
        test_back_to_back(200);
        test_random(600);
        start <= 1'b0;

        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d timestamps and checked %0d dates and times,",
                 request_count, result_count);
        $display("covering rounding carries, day and leap boundaries and full-range values.");
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("PASS timestamp_to_civil_datetime");
        else
            $display("FAIL timestamp_to_civil_datetime");
        $finish;
    end

endmodule
